// File: rtl/eat_pkg.sv
`default_nettype none

package eat_pkg;

    // Command codes of an input word.
    localparam logic [1:0] CMD_RAISE = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_ACK   = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // Action codes of a result word.
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_ACTIVATED = 3'd1;
    localparam logic [2:0] ACT_ESCALATED = 3'd2;
    localparam logic [2:0] ACT_CLEARED   = 3'd3;
    localparam logic [2:0] ACT_REMINDER  = 3'd4;
    localparam logic [2:0] ACT_ACKED     = 3'd5;

    // Reset values.
    localparam logic [31:0] RESET_INTERVAL = 32'd60000;
    localparam logic [31:0] FIRST_ID       = 32'd1;

    // One command word.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  address;
        logic [3:0]  event_type;
        logic [2:0]  severity;
        logic [31:0] event_id;
        logic [63:0] timestamp;
    } t_cmd_word;

    // One result word.
    typedef struct packed {
        logic [2:0]  action;
        logic        was_acknowledged;
        logic [5:0]  out_address;
        logic [3:0]  out_type;
        logic [2:0]  out_severity;
        logic [31:0] out_id;
        logic [63:0] out_time;
    } t_res_word;

    // One alarm table entry as stored in the slot memory.
    typedef struct packed {
        logic [5:0]  address;
        logic [3:0]  event_type;
        logic [2:0]  severity;
        logic [31:0] event_id;
        logic [63:0] time_ms;
        logic [63:0] last_emit;
        logic        acked;
    } t_entry;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: rtl/eat_cmd_if.sv
`default_nettype none

// Command channel: valid/ready handshake carrying one command word.
interface eat_cmd_if;
    import eat_pkg::*;

    logic      valid;
    logic      ready;
    t_cmd_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/eat_res_if.sv
`default_nettype none

// Result channel: valid/ready handshake carrying one result word.
interface eat_res_if;
    import eat_pkg::*;

    logic      valid;
    logic      ready;
    t_res_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/eat_slot_mem.sv
`default_nettype none

module eat_slot_mem import eat_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_entry             o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Single read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/event_alarm_table_core.sv
`default_nettype none

// Channel    Direction  Word        Handshake
// i_cmd      in         t_cmd_word  valid/ready, taken when both high
// o_res      out        t_res_word  valid/ready, taken when both high
// i_cfg_*    in         32 bits     write when i_cfg_we is high
//
// A command is taken, then the table is read one slot memory read per cycle through the shared
// key comparator and 64-bit age subtractor, and the entry is written back.
// The scan stops at the first matching or due entry.
// Reset is synchronous; it clears the slot-used bits, so no clearing pass runs.
// The result waits in an output register; a new command is taken meanwhile,
// but its write-back waits until that result has been taken.

module event_alarm_table_core import eat_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    eat_cmd_if.sink          i_cmd,
    eat_res_if.source        o_res
);

    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNTW = $clog2(SLOTS + 1);

    t_state            r_state;
    t_state            n_state;
    logic [31:0]       r_interval;
    logic [31:0]       r_next_id;
    logic [SLOTS-1:0]  r_used;
    t_cmd_word         r_in;
    logic [CNTW-1:0]   r_idx;
    logic              r_rd_vld;
    logic [IDXW-1:0]   r_rd_idx;
    logic              r_hit;
    logic [IDXW-1:0]   r_hit_idx;
    t_entry            r_hit_data;
    logic              r_free_found;
    logic [IDXW-1:0]   r_free_idx;
    logic              r_out_valid;
    t_res_word         r_out;

    t_entry            rd_data;
    logic              issue;
    logic              key_match;
    logic [64:0]       age;
    logic              due;
    logic              slot_live;
    logic              hit_now;
    logic              last_read;
    logic              out_free;
    logic              do_done;

    t_res_word         res;
    logic              wr_en;
    logic [IDXW-1:0]   wr_idx;
    t_entry            wr_data;
    logic              set_used;
    logic              clr_used;
    logic              bump_id;
    logic [31:0]       new_id;

    // Slot table storage.
    eat_slot_mem #(
        .DEPTH (SLOTS),
        .AW    (IDXW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en & do_done),
        .i_wr_addr (wr_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (issue),
        .i_rd_addr (r_idx[IDXW-1:0]),
        .o_rd_data (rd_data)
    );

    // Shared compare unit: key match, or age against the reminder interval.
    assign issue     = (r_state == S_SCAN) && (r_idx < CNTW'(SLOTS));
    assign key_match = (rd_data.address == r_in.address) &&
                       (rd_data.event_type == r_in.event_type);
    assign age       = {1'b0, r_in.timestamp} - {1'b0, rd_data.last_emit};
    assign due       = !age[64] && (age[63:0] >= {32'd0, r_interval});
    assign slot_live = r_used[r_rd_idx];
    assign hit_now   = r_rd_vld && slot_live && ((r_in.cmd == CMD_TICK) ? due : key_match);
    assign last_read = r_rd_vld && (r_rd_idx == IDXW'(SLOTS - 1));
    assign out_free  = !r_out_valid || o_res.ready;
    assign do_done   = (r_state == S_DONE) && out_free;

    // No word is taken while reset is held.
    assign i_cmd.ready   = (r_state == S_IDLE) && i_rst_n;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit_now || last_read) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Write-back entry and result word for the finished scan.
    always_comb begin
        res      = '0;
        wr_en    = 1'b0;
        wr_idx   = r_hit_idx;
        wr_data  = r_hit_data;
        set_used = 1'b0;
        clr_used = 1'b0;
        bump_id  = 1'b0;
        new_id   = r_in.event_id;
        case (r_in.cmd)
            CMD_RAISE: begin
                if (r_hit) begin
                    wr_en            = 1'b1;
                    wr_data.severity = r_in.severity;
                    wr_data.event_id = r_in.event_id;
                    wr_data.time_ms  = r_in.timestamp;
                    if (r_in.severity > r_hit_data.severity) begin
                        wr_data.last_emit    = r_in.timestamp;
                        res.action           = ACT_ESCALATED;
                        res.was_acknowledged = r_hit_data.acked;
                        res.out_address      = r_in.address;
                        res.out_type         = r_in.event_type;
                        res.out_severity     = r_in.severity;
                        res.out_id           = r_in.event_id;
                        res.out_time         = r_in.timestamp;
                    end
                end else if (r_free_found) begin
                    if (r_in.event_id == 32'd0) begin
                        new_id  = r_next_id;
                        bump_id = 1'b1;
                    end
                    wr_en              = 1'b1;
                    wr_idx             = r_free_idx;
                    wr_data.address    = r_in.address;
                    wr_data.event_type = r_in.event_type;
                    wr_data.severity   = r_in.severity;
                    wr_data.event_id   = new_id;
                    wr_data.time_ms    = r_in.timestamp;
                    wr_data.last_emit  = r_in.timestamp;
                    wr_data.acked      = 1'b0;
                    set_used           = 1'b1;
                    res.action         = ACT_ACTIVATED;
                    res.out_address    = r_in.address;
                    res.out_type       = r_in.event_type;
                    res.out_severity   = r_in.severity;
                    res.out_id         = new_id;
                    res.out_time       = r_in.timestamp;
                end
            end
            CMD_CLEAR: begin
                if (r_hit) begin
                    clr_used             = 1'b1;
                    res.action           = ACT_CLEARED;
                    res.was_acknowledged = r_hit_data.acked;
                    res.out_address      = r_hit_data.address;
                    res.out_type         = r_hit_data.event_type;
                    res.out_severity     = r_hit_data.severity;
                    res.out_id           = r_hit_data.event_id;
                    res.out_time         = r_in.timestamp;
                end
            end
            CMD_ACK: begin
                if (r_hit) begin
                    wr_en                = 1'b1;
                    wr_data.acked        = 1'b1;
                    res.action           = ACT_ACKED;
                    res.was_acknowledged = r_hit_data.acked;
                    res.out_address      = r_hit_data.address;
                    res.out_type         = r_hit_data.event_type;
                    res.out_severity     = r_hit_data.severity;
                    res.out_id           = r_hit_data.event_id;
                    res.out_time         = r_hit_data.time_ms;
                end
            end
            CMD_TICK: begin
                if (r_hit) begin
                    wr_en                = 1'b1;
                    wr_data.last_emit    = r_in.timestamp;
                    wr_data.time_ms      = r_in.timestamp;
                    res.action           = ACT_REMINDER;
                    res.was_acknowledged = r_hit_data.acked;
                    res.out_address      = r_hit_data.address;
                    res.out_type         = r_hit_data.event_type;
                    res.out_severity     = r_hit_data.severity;
                    res.out_id           = r_hit_data.event_id;
                    res.out_time         = r_in.timestamp;
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    // Sequencer, scan bookkeeping, table flags and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_interval   <= RESET_INTERVAL;
            r_next_id    <= FIRST_ID;
            r_used       <= '0;
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end

            // Take a command word and restart the scan.
            if (i_cmd.valid && i_cmd.ready) begin
                r_in         <= i_cmd.payload;
                r_idx        <= '0;
                r_rd_vld     <= 1'b0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
            end

            // One slot read and one slot check per cycle.
            if (r_state == S_SCAN) begin
                if (issue) begin
                    r_idx    <= r_idx + CNTW'(1);
                    r_rd_idx <= r_idx[IDXW-1:0];
                end
                r_rd_vld <= issue && !(hit_now || last_read);
                if (r_rd_vld && !slot_live && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_rd_idx;
                end
                if (hit_now) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_rd_idx;
                    r_hit_data <= rd_data;
                end
            end

            // Write-back and result hand-off.
            if (do_done) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
                if (set_used) begin
                    r_used[r_free_idx] <= 1'b1;
                end
                if (clr_used) begin
                    r_used[r_hit_idx] <= 1'b0;
                end
                if (bump_id) begin
                    r_next_id <= r_next_id + 32'd1;
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // An accepted word always starts a scan.
    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state == S_SCAN))
        else $error("accepted command did not start a scan");

    // A result with no action carries only zero fields.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.action == ACT_NONE)) |->
        (r_out.was_acknowledged == 1'b0 && r_out.out_address == 6'd0 &&
         r_out.out_type == 4'd0 && r_out.out_severity == 3'd0 &&
         r_out.out_id == 32'd0 && r_out.out_time == 64'd0))
        else $error("empty result carries nonzero fields");

    // A hit always points at an occupied slot.
    a_hit_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_hit) |-> r_used[r_hit_idx])
        else $error("hit on a free slot");

    // An activation occupies exactly one more slot.
    a_activate_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_done && set_used) |=>
        ($countones(r_used) == $past($countones(r_used)) + 1))
        else $error("activation did not occupy one slot");

endmodule

`default_nettype wire

// File: tb/sv/event_alarm_table_core_tb.sv
`default_nettype none

module event_alarm_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import eat_pkg::*;

    localparam int SLOTS        = 16;
    localparam int LIMIT_CYCLES = 400000;
    localparam int POST_DRAIN   = 2 * SLOTS + 8;
    localparam int PRINT_CAP    = 40;
    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 80;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // One row of the directed table: a command word and, where it is obvious,
    // the report that it must produce.
    typedef struct {
        t_cmd_word word;
        bit        fixed;
        t_res_word report;
    } t_row;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    eat_cmd_if cmd_if ();
    eat_res_if res_if ();

    event_alarm_table_core #(
        .SLOTS (SLOTS)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_cmd       (cmd_if),
        .o_res       (res_if)
    );

    // Shadow copy of the alarm table and its registers.
    t_entry      alarms     [SLOTS];
    bit          alarm_live [SLOTS];
    logic [31:0] next_auto_id;
    logic [31:0] reminder_ms;

    // Reports still owed by the block, oldest first.
    t_res_word   expected_reports [$];

    // Directed rows carry their typed report alongside the word.
    bit          drv_fixed;
    t_res_word   drv_fixed_report;

    int          errors       = 0;
    int          results_seen = 0;
    int          words_sent   = 0;
    int          cycle_count  = 0;
    int          action_seen [8];
    int          idle_pct     = 0;
    int          ready_hold   = 0;
    logic [63:0] clock_ms;
    logic [31:0] interval_now;

    // Clock.
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic t_cmd_word mk_word(logic [1:0] cmd, logic [5:0] addr, logic [3:0] typ,
                                          logic [2:0] sev, logic [31:0] id, logic [63:0] ts);
        t_cmd_word w;
        w.cmd        = cmd;
        w.address    = addr;
        w.event_type = typ;
        w.severity   = sev;
        w.event_id   = id;
        w.timestamp  = ts;
        return w;
    endfunction

    function automatic t_res_word mk_report(logic [2:0] act, logic ack, logic [5:0] addr,
                                            logic [3:0] typ, logic [2:0] sev, logic [31:0] id,
                                            logic [63:0] ts);
        t_res_word r;
        r.action           = act;
        r.was_acknowledged = ack;
        r.out_address      = addr;
        r.out_type         = typ;
        r.out_severity     = sev;
        r.out_id           = id;
        r.out_time         = ts;
        return r;
    endfunction

    function automatic t_res_word entry_report(logic [2:0] act, t_entry e);
        return mk_report(act, e.acked, e.address, e.event_type, e.severity, e.event_id,
                         e.time_ms);
    endfunction

    function automatic void alarm_table_reset();
        int i;
        for (i = 0; i < SLOTS; i++) begin
            alarm_live[i] = 1'b0;
            alarms[i]     = '0;
        end
        next_auto_id = FIRST_ID;
        reminder_ms  = RESET_INTERVAL;
    endfunction

    // Applies one command to the shadow table and returns the report it causes.
    function automatic t_res_word alarm_table_step(t_cmd_word c);
        t_res_word   r;
        int          hit;
        int          free_slot;
        int          i;
        logic [31:0] id;
        r         = '0;
        hit       = -1;
        free_slot = -1;
        for (i = 0; i < SLOTS; i++) begin
            if (hit < 0 && alarm_live[i] && alarms[i].address == c.address &&
                alarms[i].event_type == c.event_type)
                hit = i;
            if (free_slot < 0 && !alarm_live[i])
                free_slot = i;
        end
        case (c.cmd)
            CMD_RAISE: begin
                if (hit < 0) begin
                    // A new key takes the lowest free slot; a full table drops it.
                    if (free_slot >= 0) begin
                        id = c.event_id;
                        if (id == '0) begin
                            id           = next_auto_id;
                            next_auto_id = next_auto_id + 32'd1;
                        end
                        alarm_live[free_slot] = 1'b1;
                        alarms[free_slot] = t_entry'{c.address, c.event_type, c.severity, id,
                                                     c.timestamp, c.timestamp, 1'b0};
                        r = entry_report(ACT_ACTIVATED, alarms[free_slot]);
                    end
                end else begin
                    // An existing key is overwritten; only a higher severity is reported.
                    if (c.severity > alarms[hit].severity) begin
                        alarms[hit].last_emit = c.timestamp;
                        r = mk_report(ACT_ESCALATED, alarms[hit].acked, c.address, c.event_type,
                                      c.severity, c.event_id, c.timestamp);
                    end
                    alarms[hit].severity = c.severity;
                    alarms[hit].event_id = c.event_id;
                    alarms[hit].time_ms  = c.timestamp;
                end
            end
            CMD_CLEAR: begin
                if (hit >= 0) begin
                    alarms[hit].time_ms = c.timestamp;
                    r = entry_report(ACT_CLEARED, alarms[hit]);
                    alarm_live[hit] = 1'b0;
                end
            end
            CMD_ACK: begin
                if (hit >= 0) begin
                    r = entry_report(ACT_ACKED, alarms[hit]);
                    alarms[hit].acked = 1'b1;
                end
            end
            CMD_TICK: begin
                // The first entry that has been quiet long enough is reminded.
                // Entries stamped later than now are passed over.
                for (i = 0; i < SLOTS; i++) begin
                    if (r.action == ACT_NONE && alarm_live[i] &&
                        c.timestamp >= alarms[i].last_emit &&
                        c.timestamp - alarms[i].last_emit >= {32'd0, reminder_ms}) begin
                        alarms[i].last_emit = c.timestamp;
                        alarms[i].time_ms   = c.timestamp;
                        r = entry_report(ACT_REMINDER, alarms[i]);
                    end
                end
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
    endtask

    task automatic check_report(t_res_word got, t_res_word want);
        if (got.action !== want.action)
            report_mismatch("action", 64'(got.action), 64'(want.action));
        if (got.was_acknowledged !== want.was_acknowledged)
            report_mismatch("was_acknowledged", 64'(got.was_acknowledged),
                            64'(want.was_acknowledged));
        if (got.out_address !== want.out_address)
            report_mismatch("out_address", 64'(got.out_address), 64'(want.out_address));
        if (got.out_type !== want.out_type)
            report_mismatch("out_type", 64'(got.out_type), 64'(want.out_type));
        if (got.out_severity !== want.out_severity)
            report_mismatch("out_severity", 64'(got.out_severity), 64'(want.out_severity));
        if (got.out_id !== want.out_id)
            report_mismatch("out_id", 64'(got.out_id), 64'(want.out_id));
        if (got.out_time !== want.out_time)
            report_mismatch("out_time", got.out_time, want.out_time);
    endtask

    // Monitor: register writes, accepted command words and result words,
    // all sampled at the clock edge.
    always @(posedge clk) begin
        t_res_word got;
        t_res_word want;
        if (!rst_n) begin
            alarm_table_reset();
        end else begin
            if (cfg_we)
                reminder_ms = cfg_wdata;
            if (cmd_if.valid && cmd_if.ready) begin
                want = alarm_table_step(cmd_if.payload);
                if (drv_fixed)
                    want = drv_fixed_report;
                expected_reports.push_back(want);
                words_sent++;
            end
            if (res_if.valid && res_if.ready) begin
                got = res_if.payload;
                results_seen++;
                if (!$isunknown(got.action))
                    action_seen[got.action]++;
                if (expected_reports.size() == 0)
                    report_mismatch("word with no command outstanding", 64'(got.action),
                                    64'(ACT_NONE));
                else
                    check_report(got, expected_reports.pop_front());
            end
        end
    end

    // Result side back-pressure: random stalls.
    always @(posedge clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            res_if.ready <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 4) begin
            ready_hold = $urandom_range(0, 13);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Cycle limit.
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timed out after %0d cycles with %0d reports outstanding", cycle_count,
                 expected_reports.size());
        $display("event_alarm_table_core regression: fail");
        $finish;
    end

    // Advances the time base: mostly forward, sometimes right at the reminder
    // boundary, now and then backwards or to an arbitrary 64-bit value.
    function automatic logic [63:0] next_stamp();
        case ($urandom_range(0, 19))
            0:       clock_ms = {$urandom, $urandom};
            1:       clock_ms = clock_ms - $urandom_range(1, 100000);
            2, 3:    clock_ms = clock_ms + interval_now + $urandom_range(0, 2) - 1;
            default: clock_ms = clock_ms + $urandom_range(0, 20000);
        endcase
        return clock_ms;
    endfunction

    function automatic t_cmd_word random_word();
        t_cmd_word w;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            w.cmd = CMD_RAISE;
        else if (pick < 60)
            w.cmd = CMD_CLEAR;
        else if (pick < 75)
            w.cmd = CMD_ACK;
        else
            w.cmd = CMD_TICK;
        // Keys mostly come from a small pool so that re-raises, clears and
        // acknowledges find their entry.
        w.address    = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(0, 5));
        w.event_type = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(0, 3));
        w.severity   = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 7))
            0, 1, 2: w.event_id = '0;
            3:       w.event_id = '1;
            default: w.event_id = $urandom;
        endcase
        w.timestamp = next_stamp();
        return w;
    endfunction

    // Offers one word, with a random gap first, and returns once it is taken.
    task automatic send_word(t_cmd_word w, bit fixed, t_res_word report);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.payload   <= w;
        drv_fixed        <= fixed;
        drv_fixed_report <= report;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
    endtask

    // Stops offering words and waits until every report has come back.
    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        wait (expected_reports.size() == 0);
        @(posedge clk);
    endtask

    task automatic write_interval(logic [31:0] value);
        cfg_we       <= 1'b1;
        cfg_wdata    <= value;
        interval_now = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus.
    initial begin
        t_row        rows [$];
        t_cmd_word   keys [$];
        logic [31:0] interval_plan [PHASES];
        int          idle_plan [PHASES];
        int          phase;
        int          i;

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        cmd_if.valid     <= 1'b0;
        cmd_if.payload   <= '0;
        drv_fixed        <= 1'b0;
        drv_fixed_report <= '0;
        clock_ms         = '0;
        interval_now     = RESET_INTERVAL;
        foreach (action_seen[k])
            action_seen[k] = 0;

        interval_plan = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0, RESET_INTERVAL, 32'd7};
        interval_plan[3] = $urandom_range(100, 30000);
        idle_plan = '{25, 10, 0, 35, 20, 0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table. Commands on an empty table report nothing.
        rows.push_back(t_row'{mk_word(CMD_TICK, 6'd0, 4'd0, 3'd0, 32'd0, 64'd0), 1'b1, '0});
        rows.push_back(t_row'{mk_word(CMD_CLEAR, 6'd63, 4'd15, 3'd7, '1, 64'd1), 1'b1, '0});
        rows.push_back(t_row'{mk_word(CMD_ACK, 6'd63, 4'd15, 3'd7, '1, 64'd2), 1'b1, '0});
        // New keys: automatic ids count up from one, given ids pass through.
        rows.push_back(t_row'{mk_word(CMD_RAISE, 6'd0, 4'd0, 3'd0, 32'd0, 64'd0), 1'b1,
                              mk_report(ACT_ACTIVATED, 1'b0, 6'd0, 4'd0, 3'd0, 32'd1, 64'd0)});
        rows.push_back(t_row'{mk_word(CMD_RAISE, 6'd63, 4'd15, 3'd7, '1, ALL_ONES), 1'b1,
                              mk_report(ACT_ACTIVATED, 1'b0, 6'd63, 4'd15, 3'd7, '1, ALL_ONES)});
        rows.push_back(t_row'{mk_word(CMD_RAISE, 6'd21, 4'd10, 3'd2, 32'd0, 64'd100), 1'b1,
                              mk_report(ACT_ACTIVATED, 1'b0, 6'd21, 4'd10, 3'd2, 32'd2,
                                        64'd100)});
        // Same severity on an existing key is silent; higher severity escalates
        // and keeps the id of zero as given.
        rows.push_back(t_row'{mk_word(CMD_RAISE, 6'd0, 4'd0, 3'd0, 32'd5, 64'd10), 1'b1, '0});
        rows.push_back(t_row'{mk_word(CMD_RAISE, 6'd0, 4'd0, 3'd3, 32'd0, 64'd20), 1'b1,
                              mk_report(ACT_ESCALATED, 1'b0, 6'd0, 4'd0, 3'd3, 32'd0, 64'd20)});
        // First acknowledge reports the flag clear, the second reports it set.
        rows.push_back(t_row'{mk_word(CMD_ACK, 6'd0, 4'd0, 3'd0, 32'd0, 64'd30), 1'b1,
                              mk_report(ACT_ACKED, 1'b0, 6'd0, 4'd0, 3'd3, 32'd0, 64'd20)});
        rows.push_back(t_row'{mk_word(CMD_ACK, 6'd0, 4'd0, 3'd0, 32'd0, 64'd31), 1'b0, '0});
        rows.push_back(t_row'{mk_word(CMD_RAISE, 6'd0, 4'd0, 3'd1, 32'd9, 64'd35), 1'b1, '0});
        rows.push_back(t_row'{mk_word(CMD_RAISE, 6'd0, 4'd0, 3'd6, 32'd0, 64'd40), 1'b0, '0});
        // Reminders one short of the interval, exactly at it, and once more at the same stamp.
        rows.push_back(t_row'{mk_word(CMD_TICK, 6'd0, 4'd0, 3'd0, 32'd0, 64'd60039), 1'b0, '0});
        rows.push_back(t_row'{mk_word(CMD_TICK, 6'd0, 4'd0, 3'd0, 32'd0, 64'd60040), 1'b0, '0});
        rows.push_back(t_row'{mk_word(CMD_TICK, 6'd0, 4'd0, 3'd0, 32'd0, 64'd60040), 1'b0, '0});
        // Clear reports the new time; a second clear finds nothing.
        rows.push_back(t_row'{mk_word(CMD_CLEAR, 6'd63, 4'd15, 3'd0, 32'd0, 64'd5), 1'b0, '0});
        rows.push_back(t_row'{mk_word(CMD_CLEAR, 6'd63, 4'd15, 3'd0, 32'd0, 64'd6), 1'b1, '0});
        rows.push_back(t_row'{mk_word(CMD_RAISE, 6'd63, 4'd15, 3'd0, 32'd0, 64'd7), 1'b0, '0});
        rows.push_back(t_row'{mk_word(CMD_ACK, 6'd21, 4'd10, 3'd0, 32'd0, 64'd8), 1'b0, '0});
        rows.push_back(t_row'{mk_word(CMD_RAISE, 6'd42, 4'd5, 3'd4, 32'h8000_0000,
                                      64'h8000_0000_0000_0000), 1'b0, '0});
        rows.push_back(t_row'{mk_word(CMD_TICK, 6'd42, 4'd5, 3'd0, 32'd0,
                                      64'h8000_0000_0000_0000), 1'b0, '0});

        idle_pct = 20;
        foreach (rows[k])
            send_word(rows[k].word, rows[k].fixed, rows[k].report);

        // Random phases, one reminder interval each.
        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            write_interval(interval_plan[phase]);
            idle_pct = idle_plan[phase];

            // Empty the table so that every phase starts with free slots.
            keys.delete();
            for (i = 0; i < SLOTS; i++)
                if (alarm_live[i])
                    keys.push_back(mk_word(CMD_CLEAR, alarms[i].address, alarms[i].event_type,
                                           3'd0, 32'd0, next_stamp()));
            foreach (keys[k])
                send_word(keys[k], 1'b0, '0);

            // Now and then run the table past full with distinct new keys.
            if (phase % 3 == 0)
                for (i = 0; i < SLOTS + 2; i++)
                    send_word(mk_word(CMD_RAISE, 6'(40 + i), 4'd9, 3'($urandom_range(0, 7)),
                                      32'd0, next_stamp()), 1'b0, '0);

            repeat (PHASE_WORDS)
                send_word(random_word(), 1'b0, '0);
        end

        drain();
        repeat (POST_DRAIN) @(posedge clk);

        $display(
            "Sent %0d command words: directed rows, full table, time reversal, %0d intervals.",
            words_sent, PHASES + 1);
        $display(
            "Saw %0d activated, %0d escalated, %0d cleared, %0d reminders, %0d acks, %0d empty.",
            action_seen[ACT_ACTIVATED], action_seen[ACT_ESCALATED],
            action_seen[ACT_CLEARED], action_seen[ACT_REMINDER],
            action_seen[ACT_ACKED], action_seen[ACT_NONE]);
        if (errors == 0) begin
            $display("event_alarm_table_core regression: pass");
        end else begin
            $display("event_alarm_table_core regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: event_alarm_table_core.f
rtl/eat_pkg.sv
rtl/eat_cmd_if.sv
rtl/eat_res_if.sv
rtl/eat_slot_mem.sv
rtl/event_alarm_table_core.sv
tb/sv/event_alarm_table_core_tb.sv
